@@ rtl/core/ttm_pkg.sv @@
// Shared types, opcodes and constants for the track-to-MOD-cell converter.
// Used by every module in rtl/core; depends on nothing.
package ttm_pkg;

    localparam int ROWS_PER_TRACK = 64;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [11:0] PERIOD_MIN = 12'd57;
    localparam logic [11:0] PERIOD_MAX = 12'd1712;

    localparam logic [7:0] OP_ARPEGGIO   = 8'h8A;
    localparam logic [7:0] OP_SLIDE_UP   = 8'h8E;
    localparam logic [7:0] OP_SLIDE_DOWN = 8'h8F;
    localparam logic [7:0] OP_PORTA      = 8'h8B;
    localparam logic [7:0] OP_VIBRATO    = 8'h8C;
    localparam logic [7:0] OP_VOL_SLIDE  = 8'h8D;
    localparam logic [7:0] OP_SPEED      = 8'h88;
    localparam logic [7:0] OP_SET_VOL    = 8'h83;
    localparam logic [7:0] OP_INSTRUMENT = 8'h89;
    localparam logic [7:0] OP_END        = 8'h80;
    localparam logic [7:0] OP_JUMP       = 8'h91;
    localparam logic [7:0] OP_DELAY      = 8'h90;

    localparam logic [3:0] FX_ARPEGGIO   = 4'h0;
    localparam logic [3:0] FX_SLIDE_UP   = 4'h1;
    localparam logic [3:0] FX_SLIDE_DOWN = 4'h2;
    localparam logic [3:0] FX_PORTA      = 4'h3;
    localparam logic [3:0] FX_VIBRATO    = 4'h4;
    localparam logic [3:0] FX_VOL_SLIDE  = 4'hA;
    localparam logic [3:0] FX_JUMP       = 4'hB;
    localparam logic [3:0] FX_SET_VOL    = 4'hC;
    localparam logic [3:0] FX_SPEED      = 4'hF;

    typedef struct packed {
        logic [31:0] cell_word;
        logic [5:0]  row_start;
        logic [6:0]  count;
        logic        row_valid;
        logic        done;
    } cmd_t;

    // 100 / p, zero for p == 0
    function automatic logic [7:0] speed_div(input logic [7:0] p);
        logic [7:0] q;
        case (p) inside
            8'd1:             q = 8'd100;
            8'd2:             q = 8'd50;
            8'd3:             q = 8'd33;
            8'd4:             q = 8'd25;
            8'd5:             q = 8'd20;
            8'd6:             q = 8'd16;
            8'd7:             q = 8'd14;
            8'd8:             q = 8'd12;
            8'd9:             q = 8'd11;
            8'd10:            q = 8'd10;
            8'd11:            q = 8'd9;
            8'd12:            q = 8'd8;
            [8'd13:8'd14]:    q = 8'd7;
            [8'd15:8'd16]:    q = 8'd6;
            [8'd17:8'd20]:    q = 8'd5;
            [8'd21:8'd25]:    q = 8'd4;
            [8'd26:8'd33]:    q = 8'd3;
            [8'd34:8'd50]:    q = 8'd2;
            [8'd51:8'd100]:   q = 8'd1;
            default:          q = 8'd0;
        endcase
        return q;
    endfunction

endpackage

@@ rtl/core/ttm_front.sv @@
// Front end: decodes command words, keeps the parser state, issues row commands.
// Depends on ttm_pkg.
module ttm_front #(
    parameter int ROWS_PER_TRACK = ttm_pkg::ROWS_PER_TRACK
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [15:0]        word,
    input  logic               track_start,
    output logic               push,
    output ttm_pkg::cmd_t      cmd
);

    localparam logic [6:0] ROWS = 7'(ROWS_PER_TRACK);

    logic [7:0]  sample_reg, sample_next;
    logic        sample_known_reg, sample_known_next;
    logic [11:0] period_reg, period_next;
    logic [11:0] effect_reg, effect_next;
    logic        effect_known_reg, effect_known_next;
    logic [6:0]  rows_reg, rows_next;
    logic        finished_reg, finished_next;

    logic [7:0]  b_sample;
    logic        b_sample_known;
    logic [11:0] b_period;
    logic [11:0] b_effect;
    logic        b_effect_known;
    logic [6:0]  b_rows;
    logic        b_finished;

    logic [7:0]  code;
    logic [7:0]  par;
    logic        emit;
    logic        is_jump;
    logic        is_end;
    logic [11:0] cell_effect;
    logic        cell_effect_known;
    logic [7:0]  snum;
    logic        per_ok;
    logic [31:0] cell_word;
    logic [6:0]  remaining;
    logic [7:0]  blanks;
    logic [6:0]  nrows;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg       <= '0;
            sample_known_reg <= 1'b0;
            period_reg       <= '0;
            effect_reg       <= '0;
            effect_known_reg <= 1'b0;
            rows_reg         <= '0;
            finished_reg     <= 1'b0;
        end
        else if (accept)
        begin
            sample_reg       <= sample_next;
            sample_known_reg <= sample_known_next;
            period_reg       <= period_next;
            effect_reg       <= effect_next;
            effect_known_reg <= effect_known_next;
            rows_reg         <= rows_next;
            finished_reg     <= finished_next;
        end
    end

    always_comb
    begin
        b_sample       = track_start ? 8'd0  : sample_reg;
        b_sample_known = track_start ? 1'b0  : sample_known_reg;
        b_period       = track_start ? 12'd0 : period_reg;
        b_effect       = track_start ? 12'd0 : effect_reg;
        b_effect_known = track_start ? 1'b0  : effect_known_reg;
        b_rows         = track_start ? 7'd0  : rows_reg;
        b_finished     = track_start ? 1'b0  : finished_reg;

        code = word[15:8];
        par  = word[7:0];

        sample_next       = b_sample;
        sample_known_next = b_sample_known;
        period_next       = b_period;
        effect_next       = b_effect;
        effect_known_next = b_effect_known;
        rows_next         = b_rows;
        finished_next     = b_finished;

        emit    = 1'b0;
        is_jump = 1'b0;
        is_end  = 1'b0;

        if (!b_finished)
        begin
            case (code)
                ttm_pkg::OP_ARPEGGIO:
                begin
                    effect_next = {ttm_pkg::FX_ARPEGGIO, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_SLIDE_UP:
                begin
                    effect_next = {ttm_pkg::FX_SLIDE_UP, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_SLIDE_DOWN:
                begin
                    effect_next = {ttm_pkg::FX_SLIDE_DOWN, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_PORTA:
                begin
                    effect_next = {ttm_pkg::FX_PORTA, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_VIBRATO:
                begin
                    effect_next = {ttm_pkg::FX_VIBRATO, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_VOL_SLIDE:
                begin
                    effect_next = {ttm_pkg::FX_VOL_SLIDE, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_SPEED:
                begin
                    effect_next = {ttm_pkg::FX_SPEED, ttm_pkg::speed_div(par)};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_SET_VOL:
                begin
                    effect_next = {ttm_pkg::FX_SET_VOL, par};
                    effect_known_next = 1'b1;
                end
                ttm_pkg::OP_INSTRUMENT:
                begin
                    sample_next = par;
                    sample_known_next = 1'b1;
                    effect_known_next = 1'b0;
                end
                ttm_pkg::OP_END:
                begin
                    is_end = 1'b1;
                end
                ttm_pkg::OP_JUMP:
                begin
                    is_jump = 1'b1;
                    emit = 1'b1;
                end
                ttm_pkg::OP_DELAY:
                begin
                    emit = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        cell_effect       = is_jump ? {ttm_pkg::FX_JUMP, par} : b_effect;
        cell_effect_known = is_jump | b_effect_known;
        snum   = b_sample + 8'd1;
        per_ok = (b_period >= ttm_pkg::PERIOD_MIN) && (b_period <= ttm_pkg::PERIOD_MAX);
        cell_word = '0;
        if (b_sample_known && per_ok)
        begin
            cell_word[31:28] = snum[7:4];
            cell_word[27:16] = b_period;
            cell_word[15:12] = snum[3:0];
        end
        if (cell_effect_known)
        begin
            cell_word[11:0] = cell_effect;
        end

        remaining = ROWS - b_rows;
        blanks    = (par >= 8'd2) ? (par - 8'd1) : 8'd0;
        if ({1'b0, blanks} >= {2'b00, remaining} - 9'd1)
        begin
            nrows = remaining;
        end
        else
        begin
            nrows = blanks[6:0] + 7'd1;
        end

        if (emit)
        begin
            rows_next         = b_rows + nrows;
            period_next       = 12'd0;
            effect_known_next = 1'b0;
        end

        if (!b_finished && (word[13:12] != 2'b00))
        begin
            period_next = word[11:0];
        end

        if (!b_finished && (is_end || is_jump || (rows_next >= ROWS)))
        begin
            finished_next = 1'b1;
        end

        push = accept && (emit || is_end);

        cmd.cell_word = emit ? cell_word : 32'd0;
        cmd.row_start = emit ? b_rows[5:0] : 6'd0;
        cmd.count     = emit ? nrows : 7'd1;
        cmd.row_valid = emit;
        cmd.done      = finished_next;
    end

endmodule

@@ rtl/core/ttm_fifo.sv @@
// Short command queue between the front end and the row emitter.
// Depends on ttm_pkg.
module ttm_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ttm_pkg::cmd_t      push_data,
    input  logic               pop,
    output ttm_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);

    localparam int PW = ttm_pkg::FIFO_PTR_W;
    localparam logic [PW:0] DEPTH = (PW + 1)'(ttm_pkg::FIFO_DEPTH);

    ttm_pkg::cmd_t   mem_reg [ttm_pkg::FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     fill_reg, fill_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == DEPTH);

endmodule

@@ rtl/core/ttm_back.sv @@
// Row emitter: expands each queued command into output transactions.
// Depends on ttm_pkg.
module ttm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ttm_pkg::cmd_t      head,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // cell_res[31:0], row[37:32], zero pad
    output logic [1:0]         m_tuser,   // row_valid[0], track_done[1]
    output logic               m_tlast
);

    logic [5:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [31:0] cell_reg;
    logic [5:0]  row_reg;
    logic        row_valid_reg;
    logic        done_reg;
    logic        last_reg;
    logic        load;
    logic        is_last;

    always_comb
    begin
        load       = !empty && (!valid_reg || m_tready);
        is_last    = ({1'b0, idx_reg} == (head.count - 7'd1));
        pop        = load && is_last;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? 6'd0 : idx_reg + 6'd1;
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_reg      <= (idx_reg == 6'd0) ? head.cell_word : 32'd0;
            row_reg       <= head.row_start + idx_reg;
            row_valid_reg <= head.row_valid;
            done_reg      <= head.done;
            last_reg      <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, row_reg, cell_reg};
    assign m_tuser  = {done_reg, row_valid_reg};
    assign m_tlast  = last_reg;

endmodule

@@ rtl/core/tracker_track_to_mod_cells.sv @@
// Track command words in, MOD pattern cells out.
// A word's command enters the queue, then its first cell is registered.
// Throughput: one word per cycle while the queue is not full; one cell per
// cycle out while m_tready is high, so a word with N cells gives N cells out.
// Reset: rst_n clears parser state, the command queue and output tvalid.
module tracker_track_to_mod_cells #(
    parameter int ROWS_PER_TRACK = ttm_pkg::ROWS_PER_TRACK
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // word[15:0]
    input  logic        s_tuser,    // track_start[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // cell_res[31:0], row[37:32], zero pad
    output logic [1:0]  m_tuser,    // row_valid[0], track_done[1]
    output logic        m_tlast
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          empty;
    logic          full;
    ttm_pkg::cmd_t cmd;
    ttm_pkg::cmd_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    ttm_front #(
        .ROWS_PER_TRACK (ROWS_PER_TRACK)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .word        (s_tdata),
        .track_start (s_tuser),
        .push        (push),
        .cmd         (cmd)
    );

    ttm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    ttm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from empty queue");

    a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && (m_tdata == 40'd0)))
        else $error("malformed end mark");

endmodule
